// ===== sv/esce_pkg.sv =====
`default_nettype none

package esce_pkg;

  // Widths fixed by the instruction set
  localparam int INS_W  = 16;
  localparam int OPC_W  = 5;
  localparam int FLD_W  = 3;
  localparam int DATA_W = 8;
  localparam int PC_W   = 8;

  // Core sizing
  localparam int NUM_REGS    = 8;
  localparam int STACK_DEPTH = 16;
  localparam int REG_AW      = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int SP_W        = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  // Conditional jump selectors held in the sx field
  localparam logic [FLD_W-1:0] JMP_IF_NZ = 3'd5;
  localparam logic [FLD_W-1:0] JMP_IF_Z  = 3'd4;

  // Opcode = instruction bits 15..11
  typedef enum logic [OPC_W-1:0] {
    OP_LOAD_K   = 5'd0,
    OP_OR_K     = 5'd2,
    OP_XOR_K    = 5'd3,
    OP_ADD_K    = 5'd4,
    OP_ADDCY_K  = 5'd5,
    OP_SUB_K    = 5'd6,
    OP_SUBCY_K  = 5'd7,
    OP_LOAD_R   = 5'd8,
    OP_AND_R    = 5'd9,
    OP_OR_R     = 5'd10,
    OP_XOR_R    = 5'd11,
    OP_ADD_R    = 5'd12,
    OP_ADDCY_R  = 5'd13,
    OP_SUB_R    = 5'd14,
    OP_SUBCY_R  = 5'd15,
    OP_AND_K    = 5'd16,
    OP_RETURN   = 5'd18,
    OP_SHIFT    = 5'd20,
    OP_TEST_K   = 5'd21,
    OP_JUMP     = 5'd26,
    OP_CALL     = 5'd27,
    OP_TEST_R   = 5'd29
  } opcode_e;

  // Shift/rotate selector = constant field
  typedef enum logic [DATA_W-1:0] {
    SH_SLA = 8'h00,
    SH_SLX = 8'h02,
    SH_RL  = 8'h04,
    SH_SL0 = 8'h06,
    SH_SL1 = 8'h07,
    SH_SRA = 8'h08,
    SH_SRX = 8'h0A,
    SH_RR  = 8'h0C,
    SH_SR0 = 8'h0E,
    SH_SR1 = 8'h0F
  } shift_sel_e;

  // Register field folded onto the bank size
  function automatic logic [REG_AW-1:0] reg_idx(input logic [FLD_W-1:0] f);
    logic [FLD_W-1:0] v;
    v = f;
    for (int i = 0; i < 3; i++) begin
      if (v >= FLD_W'(NUM_REGS)) begin
        v = v - FLD_W'(NUM_REGS);
      end
    end
    return v[REG_AW-1:0];
  endfunction

  function automatic logic [SP_W-1:0] sp_inc(input logic [SP_W-1:0] sp);
    return (sp == SP_W'(STACK_DEPTH - 1)) ? '0 : sp + 1'b1;
  endfunction

  function automatic logic [SP_W-1:0] sp_dec(input logic [SP_W-1:0] sp);
    return (sp == '0) ? SP_W'(STACK_DEPTH - 1) : sp - 1'b1;
  endfunction

endpackage

`default_nettype wire

// ===== sv/esce_in_if.sv =====
`default_nettype none

interface esce_in_if;
  logic                         valid;
  logic                         ready;
  logic [esce_pkg::INS_W-1:0]   instruction;

  modport source (output valid, output instruction, input ready);
  modport sink   (input valid, input instruction, output ready);
endinterface

`default_nettype wire

// ===== sv/esce_out_if.sv =====
`default_nettype none

interface esce_out_if;
  logic                          valid;
  logic                          ready;
  logic [esce_pkg::PC_W-1:0]     next_pc;
  logic [esce_pkg::DATA_W-1:0]   sx_value;
  logic                          zero_out;
  logic                          carry_out;

  modport source (output valid, output next_pc, output sx_value, output zero_out,
                  output carry_out, input ready);
  modport sink   (input valid, input next_pc, input sx_value, input zero_out,
                  input carry_out, output ready);
endinterface

`default_nettype wire

// ===== sv/esce_ram.sv =====
`default_nettype none

// Simple dual-port RAM, one write and one registered read per cycle
module esce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== sv/eight_bit_softcore_execute_unit.sv =====
`default_nettype none

// Execute unit of a small 8-bit core: each item is one 16-bit instruction, and each
// item yields one result (next PC, sx after the step, zero and carry flags). One
// instruction is retired per cycle while result_o.ready holds; an accepted item passes
// from the execute stage register to the output register, from which its result leaves.
// The register bank and the call stack live in
// synchronous RAMs read at the accept edge; the ALU, flag and stack logic runs in the
// execute stage in the following cycle and writes back when the item moves on to the
// output register. A write made at the same edge as the next item's read is forwarded,
// so dependent instructions flow back to back. Registers and stack read as zero until
// first written (per-entry valid bits), so no clearing pass is needed after reset.
// Stack pointer wraps on overflow and underflow; the PC wraps at 256. Input, output,
// interrupt and unknown opcodes only advance the PC.
module eight_bit_softcore_execute_unit (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  esce_in_if.sink          item_i,
  esce_out_if.source       result_o
);

  localparam int DW = esce_pkg::DATA_W;
  localparam int AW = esce_pkg::REG_AW;
  localparam int SW = esce_pkg::SP_W;
  localparam int PW = esce_pkg::PC_W;

  // ---------------------------------------------------------------------------
  // Handshake and stage control
  // ---------------------------------------------------------------------------
  logic in_fire;
  logic s1_go;     // execute stage commits and hands its result on
  logic out_go;

  logic                        s1_vld_q;
  logic [esce_pkg::INS_W-1:0]  s1_ins_q;
  logic [AW-1:0]               s1_x_q;
  logic [AW-1:0]               s1_y_q;
  logic [SW-1:0]               s1_pop_q;

  logic out_vld_q;

  assign s1_go        = s1_vld_q && (!out_vld_q || result_o.ready);
  assign out_go       = out_vld_q && result_o.ready;
  assign item_i.ready = !s1_vld_q || s1_go;
  assign in_fire      = item_i.valid && item_i.ready;

  // ---------------------------------------------------------------------------
  // Architectural state outside the memories
  // ---------------------------------------------------------------------------
  logic [PW-1:0] pc_q;
  logic [SW-1:0] sp_q, sp_d;
  logic          carry_q, carry_d;
  logic          zero_q, zero_d;

  logic [esce_pkg::NUM_REGS-1:0]    reg_vld_q;
  logic [esce_pkg::STACK_DEPTH-1:0] stk_vld_q;

  // Last writes, forwarded to a read issued at the same edge
  logic          rf_fwd_vld_q;
  logic [AW-1:0] rf_fwd_addr_q;
  logic [DW-1:0] rf_fwd_data_q;
  logic          stk_fwd_vld_q;
  logic [SW-1:0] stk_fwd_addr_q;
  logic [PW-1:0] stk_fwd_data_q;

  // ---------------------------------------------------------------------------
  // Read addresses at accept
  // ---------------------------------------------------------------------------
  logic [AW-1:0] in_x, in_y;
  logic [SW-1:0] sp_cur;
  logic [SW-1:0] pop_addr;

  assign in_x = esce_pkg::reg_idx(item_i.instruction[10:8]);
  assign in_y = esce_pkg::reg_idx(item_i.instruction[7:5]);
  // pointer as the execute stage will see it: include the commit at this edge
  assign sp_cur   = s1_go ? sp_d : sp_q;
  assign pop_addr = esce_pkg::sp_dec(sp_cur);

  // ---------------------------------------------------------------------------
  // Memories: two copies of the bank (sx and sy ports) and the call stack
  // ---------------------------------------------------------------------------
  logic          rf_we;
  logic [DW-1:0] rf_wdata;
  logic          stk_we;
  logic [DW-1:0] rf_x_rdata, rf_y_rdata;
  logic [PW-1:0] stk_rdata;

  esce_ram #(.WIDTH(DW), .DEPTH(esce_pkg::NUM_REGS)) u_rf_x (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (s1_x_q),
    .wdata_i (rf_wdata),
    .re_i    (in_fire),
    .raddr_i (in_x),
    .rdata_o (rf_x_rdata)
  );

  esce_ram #(.WIDTH(DW), .DEPTH(esce_pkg::NUM_REGS)) u_rf_y (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (s1_x_q),
    .wdata_i (rf_wdata),
    .re_i    (in_fire),
    .raddr_i (in_y),
    .rdata_o (rf_y_rdata)
  );

  esce_ram #(.WIDTH(PW), .DEPTH(esce_pkg::STACK_DEPTH)) u_stack (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (sp_q),
    .wdata_i (pc_q),
    .re_i    (in_fire),
    .raddr_i (pop_addr),
    .rdata_o (stk_rdata)
  );

  // ---------------------------------------------------------------------------
  // Operand select: forward, else memory if written, else reset value
  // ---------------------------------------------------------------------------
  logic [DW-1:0] op_a, op_b;
  logic [PW-1:0] op_ret;

  always_comb begin
    if (rf_fwd_vld_q && rf_fwd_addr_q == s1_x_q) begin
      op_a = rf_fwd_data_q;
    end else begin
      op_a = reg_vld_q[s1_x_q] ? rf_x_rdata : '0;
    end
    if (rf_fwd_vld_q && rf_fwd_addr_q == s1_y_q) begin
      op_b = rf_fwd_data_q;
    end else begin
      op_b = reg_vld_q[s1_y_q] ? rf_y_rdata : '0;
    end
    if (stk_fwd_vld_q && stk_fwd_addr_q == s1_pop_q) begin
      op_ret = stk_fwd_data_q;
    end else begin
      op_ret = stk_vld_q[s1_pop_q] ? stk_rdata : '0;
    end
  end

  // ---------------------------------------------------------------------------
  // Execute
  // ---------------------------------------------------------------------------
  esce_pkg::opcode_e    opc;
  esce_pkg::shift_sel_e sh_sel;
  logic [DW-1:0]        k_val;
  logic [DW-1:0]        src;     // constant or sy, per instruction bit 14
  logic                 cin;
  logic [DW:0]          sum;
  logic [DW:0]          sub_rhs;
  logic [DW-1:0]        logic_res;
  logic                 r_we;
  logic [DW-1:0]        r_val;
  logic                 push;
  logic [PW-1:0]        npc;

  assign opc     = esce_pkg::opcode_e'(s1_ins_q[15:11]);
  assign sh_sel  = esce_pkg::shift_sel_e'(s1_ins_q[7:0]);
  assign k_val   = s1_ins_q[7:0];
  assign src     = s1_ins_q[14] ? op_b : k_val;
  assign cin     = s1_ins_q[11] && carry_q;   // addcy/subcy take the old carry
  assign sum     = {1'b0, op_a} + {1'b0, src} + {{DW{1'b0}}, cin};
  assign sub_rhs = {1'b0, src} + {{DW{1'b0}}, cin};

  always_comb begin
    logic_res = op_a & src;
    case (opc)
      esce_pkg::OP_OR_K, esce_pkg::OP_OR_R:   logic_res = op_a | src;
      esce_pkg::OP_XOR_K, esce_pkg::OP_XOR_R: logic_res = op_a ^ src;
      default:                                logic_res = op_a & src;
    endcase
  end

  always_comb begin
    r_we    = 1'b0;
    r_val   = op_a;
    carry_d = carry_q;
    zero_d  = zero_q;
    sp_d    = sp_q;
    push    = 1'b0;
    npc     = pc_q + 1'b1;

    unique case (opc)
      esce_pkg::OP_LOAD_K: begin
        r_we  = 1'b1;
        r_val = k_val;
      end
      esce_pkg::OP_LOAD_R: begin
        r_we  = 1'b1;
        r_val = op_b;
      end
      esce_pkg::OP_AND_K, esce_pkg::OP_AND_R,
      esce_pkg::OP_OR_K, esce_pkg::OP_OR_R,
      esce_pkg::OP_XOR_K, esce_pkg::OP_XOR_R: begin
        r_we    = 1'b1;
        r_val   = logic_res;
        zero_d  = (logic_res == '0);
        carry_d = 1'b0;
      end
      esce_pkg::OP_ADD_K, esce_pkg::OP_ADD_R,
      esce_pkg::OP_ADDCY_K, esce_pkg::OP_ADDCY_R: begin
        r_we    = 1'b1;
        r_val   = sum[DW-1:0];
        carry_d = sum[DW];
        zero_d  = (sum[DW-1:0] == '0);
      end
      esce_pkg::OP_SUB_K, esce_pkg::OP_SUB_R,
      esce_pkg::OP_SUBCY_K, esce_pkg::OP_SUBCY_R: begin
        r_we    = 1'b1;
        r_val   = op_a - sub_rhs[DW-1:0];
        carry_d = ({1'b0, op_a} < sub_rhs);   // borrow
        zero_d  = ((op_a - sub_rhs[DW-1:0]) == '0);
      end
      esce_pkg::OP_TEST_K, esce_pkg::OP_TEST_R: begin
        zero_d  = ((op_a & src) == '0);
        carry_d = ^(op_a & src);              // odd parity
      end
      esce_pkg::OP_SHIFT: begin
        r_we = 1'b1;
        case (sh_sel)
          esce_pkg::SH_RL:  begin r_val = {op_a[DW-2:0], op_a[DW-1]}; carry_d = op_a[DW-1]; end
          esce_pkg::SH_RR:  begin r_val = {op_a[0], op_a[DW-1:1]};    carry_d = op_a[0];    end
          esce_pkg::SH_SL0: begin r_val = {op_a[DW-2:0], 1'b0};       carry_d = op_a[DW-1]; end
          esce_pkg::SH_SL1: begin r_val = {op_a[DW-2:0], 1'b1};       carry_d = op_a[DW-1]; end
          esce_pkg::SH_SLA: begin r_val = {op_a[DW-2:0], carry_q};    carry_d = op_a[DW-1]; end
          esce_pkg::SH_SLX: begin r_val = {op_a[DW-2:0], op_a[0]};    carry_d = op_a[DW-1]; end
          esce_pkg::SH_SR0: begin r_val = {1'b0, op_a[DW-1:1]};       carry_d = op_a[0];    end
          esce_pkg::SH_SR1: begin r_val = {1'b1, op_a[DW-1:1]};       carry_d = op_a[0];    end
          esce_pkg::SH_SRA: begin r_val = {carry_q, op_a[DW-1:1]};    carry_d = op_a[0];    end
          esce_pkg::SH_SRX: begin r_val = {op_a[DW-1], op_a[DW-1:1]}; carry_d = op_a[0];    end
          default: begin
            // unknown selector: register and carry kept
            r_val = op_a;
          end
        endcase
        zero_d = (r_val == '0);
      end
      esce_pkg::OP_JUMP: begin
        if (s1_ins_q[10:8] == esce_pkg::JMP_IF_NZ) begin
          if (!zero_q) npc = k_val;
        end else if (s1_ins_q[10:8] == esce_pkg::JMP_IF_Z) begin
          if (zero_q) npc = k_val;
        end else begin
          npc = k_val;
        end
      end
      esce_pkg::OP_CALL: begin
        push = 1'b1;
        sp_d = esce_pkg::sp_inc(sp_q);
        npc  = k_val;
      end
      esce_pkg::OP_RETURN: begin
        sp_d = esce_pkg::sp_dec(sp_q);
        npc  = op_ret + 1'b1;
      end
      default: begin
        // I/O, interrupt and unknown opcodes: PC advance only
      end
    endcase
  end

  assign rf_we    = s1_go && r_we;
  assign rf_wdata = r_val;
  assign stk_we   = s1_go && push;

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q      <= 1'b0;
      out_vld_q     <= 1'b0;
      pc_q          <= '0;
      sp_q          <= '0;
      carry_q       <= 1'b0;
      zero_q        <= 1'b0;
      reg_vld_q     <= '0;
      stk_vld_q     <= '0;
      rf_fwd_vld_q  <= 1'b0;
      stk_fwd_vld_q <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_vld_q <= 1'b1;
      end else if (s1_go) begin
        s1_vld_q <= 1'b0;
      end
      if (s1_go) begin
        out_vld_q <= 1'b1;
      end else if (out_go) begin
        out_vld_q <= 1'b0;
      end
      if (s1_go) begin
        pc_q    <= npc;
        sp_q    <= sp_d;
        carry_q <= carry_d;
        zero_q  <= zero_d;
      end
      if (rf_we) begin
        reg_vld_q[s1_x_q] <= 1'b1;
        rf_fwd_vld_q      <= 1'b1;
      end
      if (stk_we) begin
        stk_vld_q[sp_q] <= 1'b1;
        stk_fwd_vld_q   <= 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_ins_q <= item_i.instruction;
      s1_x_q   <= in_x;
      s1_y_q   <= in_y;
      s1_pop_q <= pop_addr;
    end
    if (rf_we) begin
      rf_fwd_addr_q <= s1_x_q;
      rf_fwd_data_q <= rf_wdata;
    end
    if (stk_we) begin
      stk_fwd_addr_q <= sp_q;
      stk_fwd_data_q <= pc_q;
    end
    if (s1_go) begin
      result_o.next_pc   <= npc;
      result_o.sx_value  <= r_we ? r_val : op_a;
      result_o.zero_out  <= zero_d;
      result_o.carry_out <= carry_d;
    end
  end

  assign result_o.valid = out_vld_q;

endmodule

`default_nettype wire
